[hdl/tcce_pkg.sv]
// Shared types and constants for the text console cursor engine.
// No dependencies; used by tcce_dp, tcce_ctrl and the core top level.
`timescale 1ns / 1ps

package tcce_pkg;

	localparam logic [7:0] CH_BACKSPACE    = 8'd8;
	localparam logic [7:0] CH_TAB          = 8'd9;
	localparam logic [7:0] CH_NEWLINE      = 8'd10;
	localparam logic [7:0] CH_SPACE        = 8'd32;
	localparam logic [3:0] TAB_STOP        = 4'd8;
	localparam logic [7:0] MIN_LAST_COLUMN = 8'd7;

	localparam logic [7:0] LAST_COLUMN_RESET = 8'd127;
	localparam logic [7:0] LAST_ROW_RESET    = 8'd47;

	localparam logic REG_LAST_COLUMN = 1'b0;
	localparam logic REG_LAST_ROW    = 1'b1;

	localparam logic CMD_DRAW   = 1'b0;
	localparam logic CMD_SCROLL = 1'b1;

	typedef struct packed {
		logic [7:0]  char_code;
		logic [31:0] fg_color;
		logic [31:0] bg_color;
	} in_item_t;

	typedef struct packed {
		logic        command;
		logic [7:0]  cell_column;
		logic [7:0]  cell_row;
		logic [7:0]  glyph;
		logic [31:0] draw_fg;
		logic [31:0] draw_bg;
		logic        last;
	} out_item_t;

	typedef struct packed {
		logic load;
		logic draw_step;
		logic scroll_emit;
	} dp_cmd_t;

	typedef struct packed {
		logic slot_free;
		logic is_newline;
		logic nl_scroll;
		logic step_scroll;
		logic count_one;
		logic count_zero;
	} dp_status_t;

endpackage

[hdl/tcce_dp.sv]
// Datapath: cursor, screen limits, latched request, remaining count, output register.
// Depends on tcce_pkg; driven by tcce_ctrl through dp_cmd_t.
`timescale 1ns / 1ps

module tcce_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  tcce_pkg::in_item_t  in_data,
	input  logic                cfg_we,
	input  logic                cfg_index,
	input  logic [7:0]          cfg_data,
	input  tcce_pkg::dp_cmd_t   cmd,
	output tcce_pkg::dp_status_t status,
	output logic                out_valid,
	input  logic                out_ready,
	output tcce_pkg::out_item_t out_data
);

	logic [7:0]  last_column_q, last_row_q;
	logic [7:0]  col_q, row_q;
	logic [7:0]  glyph_q;
	logic [31:0] fg_q, bg_q;
	logic        adv_q;
	logic [3:0]  count_q;
	logic        out_valid_q;
	tcce_pkg::out_item_t out_q;

	logic [7:0] lc, col_c, row_c;
	logic [3:0] tab_count;
	logic       col_at_end, row_at_end;

	assign lc    = (last_column_q < tcce_pkg::MIN_LAST_COLUMN) ?
		tcce_pkg::MIN_LAST_COLUMN : last_column_q;
	assign col_c = (col_q > lc) ? lc : col_q;
	assign row_c = (row_q > last_row_q) ? last_row_q : row_q;
	assign tab_count = tcce_pkg::TAB_STOP - {1'b0, col_c[2:0]};

	assign col_at_end = (col_q == lc);
	assign row_at_end = (row_q == last_row_q);

	assign status.slot_free   = !out_valid_q || out_ready;
	assign status.is_newline  = (in_data.char_code == tcce_pkg::CH_NEWLINE);
	assign status.nl_scroll   = (row_c == last_row_q);
	assign status.step_scroll = adv_q && col_at_end && row_at_end;
	assign status.count_one   = (count_q == 4'd1);
	assign status.count_zero  = (count_q == 4'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_column_q <= tcce_pkg::LAST_COLUMN_RESET;
			last_row_q    <= tcce_pkg::LAST_ROW_RESET;
		end else if (cfg_we) begin
			if (cfg_index == tcce_pkg::REG_LAST_COLUMN) begin
				last_column_q <= cfg_data;
			end
			if (cfg_index == tcce_pkg::REG_LAST_ROW) begin
				last_row_q <= cfg_data;
			end
		end
	end

	// cursor and remaining count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			row_q   <= '0;
			count_q <= '0;
		end else if (cmd.load) begin
			case (in_data.char_code)
				tcce_pkg::CH_NEWLINE: begin
					col_q   <= '0;
					row_q   <= (row_c == last_row_q) ? row_c : row_c + 8'd1;
					count_q <= 4'd0;
				end
				tcce_pkg::CH_TAB: begin
					col_q   <= col_c;
					row_q   <= row_c;
					count_q <= tab_count;
				end
				tcce_pkg::CH_BACKSPACE: begin
					if (col_c != 8'd0) begin
						col_q <= col_c - 8'd1;
						row_q <= row_c;
					end else if (row_c != 8'd0) begin
						col_q <= lc;
						row_q <= row_c - 8'd1;
					end else begin
						col_q <= col_c;
						row_q <= row_c;
					end
					count_q <= 4'd1;
				end
				default: begin
					col_q   <= col_c;
					row_q   <= row_c;
					count_q <= 4'd1;
				end
			endcase
		end else if (cmd.draw_step) begin
			count_q <= count_q - 4'd1;
			if (adv_q) begin
				if (col_at_end) begin
					col_q <= '0;
					if (!row_at_end) begin
						row_q <= row_q + 8'd1;
					end
				end else begin
					col_q <= col_q + 8'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			fg_q  <= in_data.fg_color;
			bg_q  <= in_data.bg_color;
			adv_q <= (in_data.char_code != tcce_pkg::CH_BACKSPACE);
			if (in_data.char_code == tcce_pkg::CH_TAB ||
			    in_data.char_code == tcce_pkg::CH_BACKSPACE) begin
				glyph_q <= tcce_pkg::CH_SPACE;
			end else begin
				glyph_q <= in_data.char_code;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.draw_step || cmd.scroll_emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.draw_step) begin
			out_q.command     <= tcce_pkg::CMD_DRAW;
			out_q.cell_column <= col_q;
			out_q.cell_row    <= row_q;
			out_q.glyph       <= glyph_q;
			out_q.draw_fg     <= fg_q;
			out_q.draw_bg     <= bg_q;
			out_q.last        <= status.count_one && !status.step_scroll;
		end else if (cmd.scroll_emit) begin
			out_q.command     <= tcce_pkg::CMD_SCROLL;
			out_q.cell_column <= '0;
			out_q.cell_row    <= '0;
			out_q.glyph       <= '0;
			out_q.draw_fg     <= '0;
			out_q.draw_bg     <= '0;
			out_q.last        <= status.count_zero;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

[hdl/tcce_ctrl.sv]
// Controller: sequences load, draw and scroll steps of one request.
// Depends on tcce_pkg; commands tcce_dp through dp_cmd_t.
`timescale 1ns / 1ps

module tcce_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  tcce_pkg::dp_status_t status,
	output tcce_pkg::dp_cmd_t    cmd
);

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_DRAW   = 2'd1;
	localparam logic [1:0] S_SCROLL = 2'd2;

	logic [1:0] state_q, state_d;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					if (!status.is_newline) begin
						state_d = S_DRAW;
					end else if (status.nl_scroll) begin
						state_d = S_SCROLL;
					end
				end
			end
			S_DRAW: begin
				if (status.slot_free) begin
					cmd.draw_step = 1'b1;
					if (status.step_scroll) begin
						state_d = S_SCROLL;
					end else if (status.count_one) begin
						state_d = S_IDLE;
					end
				end
			end
			S_SCROLL: begin
				if (status.slot_free) begin
					cmd.scroll_emit = 1'b1;
					state_d = status.count_zero ? S_IDLE : S_DRAW;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	a_emit_needs_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.draw_step || cmd.scroll_emit) |-> status.slot_free)
		else $error("result emitted while output register busy");

	a_one_command: assert property (@(posedge clk) disable iff (!arst_n)
		$countones({cmd.load, cmd.draw_step, cmd.scroll_emit}) <= 1)
		else $error("more than one datapath command");

	a_draw_has_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DRAW) |-> !status.count_zero)
		else $error("draw state with nothing left to draw");

	a_final_scroll_idles: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.scroll_emit && status.count_zero) |=> (state_q == S_IDLE))
		else $error("final scroll did not return to idle");

endmodule

[hdl/text_console_cursor_engine_core.sv]
// Text console cursor engine, top level.
// Depends on tcce_pkg, tcce_ctrl and tcce_dp.
//
// Usage:
//   in_valid/in_ready/in_data carry one character request (byte and colors).
//   out_valid/out_ready/out_data carry draw and scroll results; last marks the
//   final result of a request. A newline that stays on screen gives no result.
//   cfg_we/cfg_index/cfg_data write last_column (index 0) and last_row
//   (index 1); write them only while the engine is idle.
// Sequencing:
//   A request is taken in the idle state, then each result costs one cycle of
//   the controller while the output register is free. A plain character gives
//   one draw, plus a scroll when it wraps past the last row; a backspace gives
//   one draw; a tab gives up to eight draws and at most one scroll. The single
//   output register sets this pace; each result is registered before it shows.
// Reset: cursor at (0, 0), last_column 127, last_row 47, no result pending.
// Stall: while out_ready is low the held result stays and the controller
//   waits; in_ready returns only once all results have been queued.
`timescale 1ns / 1ps

module text_console_cursor_engine_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  tcce_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output tcce_pkg::out_item_t out_data,
	input  logic                cfg_we,
	input  logic                cfg_index,
	input  logic [7:0]          cfg_data
);

	tcce_pkg::dp_cmd_t    cmd;
	tcce_pkg::dp_status_t status;

	tcce_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	tcce_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.status    (status),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule
